@@ design/pdb_pkg.sv @@
// shared types, constants and lookup tables for the pulsing decay brightness block
// no dependencies
`default_nettype none

package pdb_pkg;

    localparam int PADDR_W = 4;

    // register index codes (byte address bits [3:2])
    localparam logic [1:0] REG_DECAY = 2'd0;
    localparam logic [1:0] REG_DEPTH = 2'd1;
    localparam logic [1:0] REG_RATE  = 2'd2;

    localparam logic [15:0] DECAY_RST = 16'd1000;
    localparam logic [7:0]  DEPTH_RST = 8'd77;
    localparam logic [15:0] RATE_RST  = 16'd393;

    localparam logic [16:0] LOG2E_Q16  = 17'd94548;
    localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
    localparam logic [7:0]  LVL_MIN    = 8'd50;
    localparam logic [7:0]  LVL_MAX    = 8'd255;
    localparam logic [15:0] PRESS_TOP  = 16'd150;
    localparam logic [7:0]  PRESS_GAIN = 8'd205;
    // ceil(2^24 / 150), exact for dividends below 30546
    localparam logic [16:0] RECIP_150  = 17'd111849;
    localparam logic [15:0] SIN_ONE    = 16'd32768;
    localparam logic [16:0] Q16_ONE    = 17'd65536;
    // floor(2^48 / 2pi_q16): quotient estimate for a 48-bit phase, at most one low
    localparam logic [29:0] PH_RECIP   = 30'd683564997;
    // floor(2^40 / 2pi_q16): turn fraction estimate, at most one low
    localparam logic [21:0] U_RECIP    = 22'd2670175;

    // divider step counts
    localparam logic [4:0] STEPS_TAU = 5'd20;

    typedef struct packed {
        logic               op;
        logic [31:0]        now_ms;
        logic [7:0]         pin;
        logic               touched;
        logic signed [15:0] pressure;
    } pdb_in_t;

    typedef struct packed {
        logic [7:0] intensity;
        logic       done_res;
    } pdb_out_t;

    typedef struct packed {
        logic [15:0] decay_time_ms;
        logic [7:0]  mod_depth;
        logic [15:0] pulse_rate;
    } pdb_cfg_t;

    typedef struct packed {
        logic        start;
        logic [18:0] rem_init;
        logic [29:0] dvd;
        logic [18:0] divisor;
        logic [4:0]  steps;
    } pdb_div_cmd_t;

    typedef struct packed {
        logic        busy;
        logic [18:0] rem;
        logic [19:0] quo;
    } pdb_div_sts_t;

    // 2^(-k/16) in q16
    function automatic logic [16:0] exp2_tab(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    // quarter-wave sine in q15, steps of pi/32
    function automatic logic [15:0] sin_tab(input logic [4:0] i);
        logic [15:0] v;
        case (i)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3212;
            5'd2:    v = 16'd6393;
            5'd3:    v = 16'd9512;
            5'd4:    v = 16'd12540;
            5'd5:    v = 16'd15447;
            5'd6:    v = 16'd18205;
            5'd7:    v = 16'd20788;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd25330;
            5'd10:   v = 16'd27246;
            5'd11:   v = 16'd28899;
            5'd12:   v = 16'd30274;
            5'd13:   v = 16'd31357;
            5'd14:   v = 16'd32138;
            5'd15:   v = 16'd32610;
            5'd16:   v = 16'd32768;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/pdb_div_unit.sv @@
// restoring divide / modulo unit, one quotient bit per cycle
// depends on pdb_pkg
`default_nettype none

module pdb_div_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pdb_pkg::pdb_div_cmd_t cmd,
    output pdb_pkg::pdb_div_sts_t sts
);
    import pdb_pkg::*;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [18:0] rem_reg;
    logic [29:0] dvd_reg;
    logic [18:0] divisor_reg;
    logic [19:0] quo_reg;

    logic [19:0] cand;
    logic [19:0] diff;
    logic        ge;

    assign cand = {rem_reg, dvd_reg[29]};
    assign ge   = cand >= {1'b0, divisor_reg};
    assign diff = cand - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.start) begin
            busy_reg    <= 1'b1;
            cnt_reg     <= cmd.steps;
            rem_reg     <= cmd.rem_init;
            dvd_reg     <= cmd.dvd;
            divisor_reg <= cmd.divisor;
            quo_reg     <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[18:0] : cand[18:0];
            quo_reg  <= {quo_reg[18:0], ge};
            dvd_reg  <= {dvd_reg[28:0], 1'b0};
            cnt_reg  <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.rem  = rem_reg;
    assign sts.quo  = quo_reg;

endmodule

`default_nettype wire

@@ design/pdb_cfg_regs.sv @@
// apb-style configuration registers: decay time, modulation depth, pulse rate
// depends on pdb_pkg
`default_nettype none

module pdb_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pdb_pkg::pdb_cfg_t           cfg
);
    import pdb_pkg::*;

    logic [15:0] decay_reg;
    logic [7:0]  depth_reg;
    logic [15:0] rate_reg;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= DECAY_RST;
            depth_reg <= DEPTH_RST;
            rate_reg  <= RATE_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_DECAY: decay_reg <= pwdata[15:0];
                REG_DEPTH: depth_reg <= pwdata[7:0];
                REG_RATE:  rate_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DECAY: prdata = {16'd0, decay_reg};
            REG_DEPTH: prdata = {24'd0, depth_reg};
            REG_RATE:  prdata = {16'd0, rate_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign cfg.decay_time_ms = decay_reg;
    assign cfg.mod_depth     = depth_reg;
    assign cfg.pulse_rate    = rate_reg;

endmodule

`default_nettype wire

@@ design/pulsing_decay_brightness_core.sv @@
// channel   dir  handshake          payload
// s_        in   s_valid / s_ready  pdb_in_t  (touch or tick item)
// m_        out  m_valid / m_ready  pdb_out_t (intensity, done_res)
// cfg       in   psel/penable       decay_time_ms, mod_depth, pulse_rate
//
// a touch item is taken in S_IDLE and leaves the block ready; a tick item while
// active raises m_valid once S_DIV_TAU has waited on the divider for t/tau (20 steps)
// and the 14 other stages from S_PREP to S_OUT have run.
// s_ready is low from the accept of an active tick until its result is taken on m_;
// the next item is taken only after S_HOLD sees m_ready and returns to S_IDLE.
// reset is synchronous, active low, and leaves the block idle.
// depends on pdb_pkg, pdb_div_unit, pdb_cfg_regs
`default_nettype none

module pulsing_decay_brightness_core #(
    parameter int PIN_COUNT = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pdb_pkg::pdb_in_t            s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pdb_pkg::pdb_out_t           m_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pdb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_DIV_TAU, S_EXP_Y, S_EXP_V, S_ENV,
        S_PH_MUL, S_PH_Q, S_PH_R, S_PH_FIX, S_U_MUL, S_U_REM, S_U_FIX,
        S_SIN, S_DEPTH, S_OUT, S_HOLD
    } state_t;

    state_t       state_reg;
    pdb_cfg_t     cfg;
    pdb_div_cmd_t div_cmd;
    pdb_div_sts_t div_sts;

    logic        active_reg;
    logic [31:0] start_time_reg;
    logic [7:0]  level_reg;
    logic [31:0] t_reg;
    logic        ovf_reg;
    logic [47:0] prod_reg;
    logic [20:0] y_reg;
    logic [16:0] v_reg;
    logic [24:0] env_reg;
    logic [53:0] ph_a_reg;
    logic [53:0] ph_b_reg;
    logic [29:0] q_reg;
    logic [19:0] rm_reg;
    logic [18:0] r_reg;
    logic [15:0] u_est_reg;
    logic [19:0] urem_reg;
    logic [15:0] u_reg;
    logic [15:0] s_reg;
    logic        neg_reg;
    logic [16:0] m_reg;
    logic        m_valid_reg;
    pdb_out_t    m_item_reg;

    pdb_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdb_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .sts     (div_sts)
    );

    logic        accept;
    logic        pin_ok;
    logic [7:0]  touch_level;
    logic [15:0] gain_prod;
    logic [32:0] recip_prod;
    logic [15:0] tau_eff;
    logic [36:0] y_prod;
    logic [11:0] exp_step;
    logic [23:0] exp_mul;
    logic [16:0] e_val;
    logic [4:0]  k_idx;
    logic [53:0] ph_sum;
    logic [48:0] qm_prod;
    logic [40:0] ue_prod;
    logic [34:0] um_prod;
    logic [14:0] sq;
    logic [4:0]  s_idx;
    logic [21:0] sin_mul;
    logic [15:0] s_val;
    logic [23:0] depth_prod;
    logic [16:0] d_val;
    logic [41:0] val_prod;
    logic [9:0]  val_raw;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign pin_ok  = {1'b0, s_item.pin} < 9'(PIN_COUNT);

    // level = clamp(p*205/150 + 50); only 0..149 needs the divide
    assign gain_prod  = s_item.pressure[7:0] * PRESS_GAIN;
    assign recip_prod = gain_prod * RECIP_150;
    always_comb begin
        if (s_item.pressure[15]) begin
            touch_level = LVL_MIN;
        end else if (s_item.pressure >= $signed(PRESS_TOP)) begin
            touch_level = LVL_MAX;
        end else begin
            touch_level = recip_prod[31:24] + LVL_MIN;
        end
    end

    assign tau_eff = (cfg.decay_time_ms == 16'd0) ? 16'd1 : cfg.decay_time_ms;
    assign y_prod  = div_sts.quo * LOG2E_Q16;

    // 2^-f by table and linear interpolation on the low 12 bits
    assign k_idx    = {1'b0, y_reg[15:12]};
    assign exp_step = 12'(exp2_tab(k_idx) - exp2_tab(k_idx + 5'd1));
    assign exp_mul  = exp_step * y_reg[11:0];
    assign e_val    = ovf_reg ? 17'd0 : (v_reg >> y_reg[20:16]);

    // phase reduction by reciprocal estimate; each estimate needs one fix-up at most
    assign ph_sum  = ph_a_reg + {24'd0, ph_b_reg[53:24]};
    assign qm_prod = q_reg * TWO_PI_Q16;
    assign ue_prod = r_reg * U_RECIP;
    assign um_prod = u_est_reg * TWO_PI_Q16;

    // quadrant fold of the turn fraction
    always_comb begin
        if (u_reg[14]) begin
            sq = 15'h4000 - {1'b0, u_reg[13:0]};
        end else begin
            sq = {1'b0, u_reg[13:0]};
        end
    end
    assign s_idx   = sq[14:10];
    assign sin_mul = 16'(sin_tab(s_idx + 5'd1) - sin_tab(s_idx)) * sq[9:0];
    assign s_val   = (s_idx >= 5'd16) ? SIN_ONE : sin_tab(s_idx) + 16'(sin_mul >> 10);

    assign depth_prod = cfg.mod_depth * s_reg;
    assign d_val      = 17'(depth_prod >> 7);
    assign val_prod   = env_reg * m_reg;
    assign val_raw    = val_prod[41:32];

    always_comb begin
        div_cmd = '0;
        case (state_reg)
            S_PREP: begin
                div_cmd.start    = 1'b1;
                div_cmd.rem_init = {3'd0, t_reg[19:4]};
                div_cmd.dvd      = {t_reg[3:0], 26'd0};
                div_cmd.divisor  = {3'd0, tau_eff};
                div_cmd.steps    = STEPS_TAU;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            active_reg     <= 1'b0;
            start_time_reg <= '0;
            level_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (!s_item.op) begin
                            if (pin_ok && s_item.touched) begin
                                level_reg      <= touch_level;
                                start_time_reg <= s_item.now_ms;
                                active_reg     <= 1'b1;
                            end
                        end else if (active_reg) begin
                            t_reg     <= s_item.now_ms - start_time_reg;
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    prod_reg  <= cfg.pulse_rate * t_reg;
                    ovf_reg   <= t_reg >= {12'd0, tau_eff, 4'd0};
                    state_reg <= S_DIV_TAU;
                end
                S_DIV_TAU: begin
                    if (!div_sts.busy) begin
                        state_reg <= S_EXP_Y;
                    end
                end
                S_EXP_Y: begin
                    y_reg     <= y_prod[36:16];
                    state_reg <= S_EXP_V;
                end
                S_EXP_V: begin
                    v_reg     <= exp2_tab(k_idx) - 17'(exp_mul >> 12);
                    state_reg <= S_ENV;
                end
                S_ENV: begin
                    env_reg   <= level_reg * e_val;
                    state_reg <= S_PH_MUL;
                end
                S_PH_MUL: begin
                    ph_a_reg  <= prod_reg[47:24] * PH_RECIP;
                    ph_b_reg  <= prod_reg[23:0] * PH_RECIP;
                    state_reg <= S_PH_Q;
                end
                S_PH_Q: begin
                    q_reg     <= ph_sum[53:24];
                    state_reg <= S_PH_R;
                end
                S_PH_R: begin
                    // true remainder is below 2^20, so the low bits suffice
                    rm_reg    <= prod_reg[19:0] - qm_prod[19:0];
                    state_reg <= S_PH_FIX;
                end
                S_PH_FIX: begin
                    r_reg     <= (rm_reg >= {1'b0, TWO_PI_Q16})
                                 ? 19'(rm_reg - {1'b0, TWO_PI_Q16}) : rm_reg[18:0];
                    state_reg <= S_U_MUL;
                end
                S_U_MUL: begin
                    u_est_reg <= ue_prod[39:24];
                    state_reg <= S_U_REM;
                end
                S_U_REM: begin
                    urem_reg  <= {r_reg[3:0], 16'd0} - um_prod[19:0];
                    state_reg <= S_U_FIX;
                end
                S_U_FIX: begin
                    u_reg     <= (urem_reg >= {1'b0, TWO_PI_Q16})
                                 ? u_est_reg + 16'd1 : u_est_reg;
                    state_reg <= S_SIN;
                end
                S_SIN: begin
                    s_reg     <= s_val;
                    neg_reg   <= u_reg[15];
                    state_reg <= S_DEPTH;
                end
                S_DEPTH: begin
                    m_reg     <= neg_reg ? Q16_ONE - d_val : Q16_ONE + d_val;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    m_item_reg.intensity <= (val_raw > 10'd255) ? LVL_MAX : val_raw[7:0];
                    m_item_reg.done_res  <= (env_reg < 25'd65536);
                    if (env_reg < 25'd65536) begin
                        active_reg <= 1'b0;
                    end
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_HOLD;
                end
                S_HOLD: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/pdb_checker.sv @@
// port-level checks for the pulsing decay brightness core, bound to the top level
// depends on pdb_pkg
`default_nettype none

module pdb_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input pdb_pkg::pdb_out_t m_item,
    input logic              pready
);
    import pdb_pkg::*;

    // one item at a time: never ready while a result is held
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("s_ready high while result pending");

    // a tick needs many cycles, so no result right after any accept
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid)
        else $error("result right after accept");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("stalled result changed");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind pulsing_decay_brightness_core pdb_checker u_pdb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item),
    .pready  (pready)
);

`default_nettype wire

@@ tb/pulsing_decay_brightness_core_test.sv @@
// testbench for pulsing_decay_brightness_core: directed table, then random touch/tick bursts
// under several register settings, each result checked against a typed value or an in-bench glow predictor
// depends on pdb_pkg and pulsing_decay_brightness_core
`default_nettype none

module pulsing_decay_brightness_core_test;
    import pdb_pkg::*;

    localparam int NPIN = 16;
    localparam int WATCH_LIMIT = 5000;
    localparam int SETTLE_CYC = 100;
    localparam int LONG_HOLD = 300;

    typedef struct {
        bit       typed;
        pdb_out_t val;
    } glow_exp_t;

    typedef struct {
        pdb_in_t  item;
        bit       typed;
        pdb_out_t val;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pdb_in_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pdb_out_t m_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pulsing_decay_brightness_core #(.PIN_COUNT(NPIN)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor copy of registers and glow state
    logic [15:0] tau_cfg = DECAY_RST;
    logic [7:0]  depth_cfg = DEPTH_RST;
    logic [15:0] rate_cfg = RATE_RST;
    bit          glow_on = 0;
    logic [31:0] glow_t0 = '0;
    logic [7:0]  glow_lvl = '0;

    glow_exp_t   pending_glow[$];
    glow_exp_t   typed_sent[$];
    int          errors = 0;
    bit          idle_on = 1;
    bit          hold_long = 0;
    int          quiet_cycles = 0;

    const int unsigned pow2_q16[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
        48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    const int unsigned qsine_q15[17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788,
        23170, 25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};

    // exp(-t/tau) in q16
    function automatic longint unsigned decay_factor(logic [31:0] t);
        longint unsigned tau, x, y, n, f, k, r, v;
        tau = (tau_cfg == 0) ? 1 : tau_cfg;
        x = ({32'd0, t} << 16) / tau;
        if (x >= (64'd16 << 16)) return 0;
        y = (x * 94548) >> 16;
        n = y >> 16;
        f = y & 16'hFFFF;
        k = f >> 12;
        r = f & 12'hFFF;
        v = pow2_q16[k] - (((pow2_q16[k] - pow2_q16[k + 1]) * r) >> 12);
        return (n < 32) ? (v >> n) : 0;
    endfunction

    // returns 1 with a result in res when the item produces one
    function automatic bit glow_step(pdb_in_t it, output pdb_out_t res);
        int p, lv;
        logic [31:0] t;
        longint unsigned env, ph, u, q, quad, i, s, d, m, val;
        bit neg;
        res = '0;
        if (it.op == 1'b0) begin
            if (it.pin >= NPIN || !it.touched) return 0;
            p = it.pressure;
            lv = (p * 205) / 150 + 50;
            if (lv < 50) lv = 50;
            if (lv > 255) lv = 255;
            glow_lvl = lv[7:0];
            glow_t0 = it.now_ms;
            glow_on = 1;
            return 0;
        end
        if (!glow_on) return 0;
        t = it.now_ms - glow_t0;
        env = glow_lvl * decay_factor(t);
        ph = (longint'(rate_cfg) * t) % 411775;
        u = (ph << 16) / 411775;
        quad = (u >> 14) & 3;
        q = u & 16'h3FFF;
        if (quad & 1) q = 16'h4000 - q;
        neg = (quad >= 2);
        i = q >> 10;
        if (i >= 16) s = qsine_q15[16];
        else s = qsine_q15[i] + (((qsine_q15[i + 1] - qsine_q15[i]) * (q & 10'h3FF)) >> 10);
        d = (depth_cfg * s) >> 7;
        m = neg ? 65536 - d : 65536 + d;
        val = (env * m) >> 32;
        if (val > 255) val = 255;
        res.intensity = val[7:0];
        res.done_res = (env < 65536);
        if (res.done_res) glow_on = 0;
        return 1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // accept monitor and result checker
    always @(posedge aclk) begin
        glow_exp_t e, tp;
        pdb_out_t res;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tp = typed_sent.pop_front();
                if (glow_step(s_item, res)) begin
                    e.typed = tp.typed;
                    e.val = tp.typed ? tp.val : res;
                    pending_glow.push_back(e);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_glow.size() == 0) begin
                    report_mismatch("unexpected item", m_item.intensity, -1);
                end else begin
                    e = pending_glow.pop_front();
                    if (m_item.intensity !== e.val.intensity)
                        report_mismatch("intensity", m_item.intensity, e.val.intensity);
                    if (m_item.done_res !== e.val.done_res)
                        report_mismatch("done_res", m_item.done_res, e.val.done_res);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    // result receiver with random stalls
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_long) begin
                stall = LONG_HOLD;
                hold_long = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 12) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_item(pdb_in_t it, bit typed = 0, pdb_out_t val = '0);
        int gap;
        glow_exp_t tp;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        tp.typed = typed;
        tp.val = val;
        typed_sent.push_back(tp);
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_glow.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DECAY: tau_cfg = data[15:0];
            REG_DEPTH: depth_cfg = data[7:0];
            REG_RATE:  rate_cfg = data[15:0];
            default: ;
        endcase
    endtask

    function automatic pdb_in_t mk(logic op, logic [31:0] now, logic [7:0] pin,
                                   logic tch, logic signed [15:0] pr);
        pdb_in_t it;
        it.op = op;
        it.now_ms = now;
        it.pin = pin;
        it.touched = tch;
        it.pressure = pr;
        return it;
    endfunction

    function automatic pdb_out_t ov(logic [7:0] v, logic dn);
        pdb_out_t o;
        o.intensity = v;
        o.done_res = dn;
        return o;
    endfunction

    stim_row_t directed[$];

    initial begin
        logic [15:0] taus[7];
        logic [7:0]  depths[7];
        logic [15:0] rates[7];
        logic [31:0] clock_ms;
        int items, burst;
        longint unsigned tau_eff;
        pdb_in_t it;

        taus = '{1000, 0, 65535, 1, 200, 0, 0};
        depths = '{77, 255, 0, 255, 128, 0, 0};
        rates = '{393, 65535, 0, 1, 9000, 0, 0};

        directed = '{
            '{mk(1, 0, 0, 1, 0), 0, '0},                 // tick after reset, idle
            '{mk(0, 1000, 0, 1, 150), 0, '0},
            '{mk(1, 1000, 0, 0, 0), 1, ov(255, 0)},      // top of the pressure map
            '{mk(0, 5, 15, 1, -32768), 0, '0},           // retouch, pressure clamps low
            '{mk(1, 5, 0, 1, 0), 1, ov(50, 0)},
            '{mk(1, 20005, 0, 0, 0), 1, ov(0, 1)},       // envelope gone, glow ends
            '{mk(1, 20006, 0, 0, 0), 0, '0},
            '{mk(0, 10, 0, 0, 100), 0, '0},              // release is ignored
            '{mk(1, 10, 0, 0, 0), 0, '0},
            '{mk(0, 10, 16, 1, 100), 0, '0},             // pin out of range
            '{mk(1, 10, 0, 0, 0), 0, '0},
            '{mk(0, 10, 255, 1, 100), 0, '0},
            '{mk(1, 10, 0, 0, 0), 0, '0},
            '{mk(0, 0, 1, 1, 0), 0, '0},
            '{mk(1, 0, 0, 0, 0), 1, ov(50, 0)},
            '{mk(0, 32'hFFFF_FFF0, 3, 1, 32767), 0, '0}, // pressure clamps high
            '{mk(1, 32'h10, 0, 1, 0), 0, '0},            // counter wraps
            '{mk(1, 32'h100, 0, 1, 0), 0, '0},
            '{mk(0, 500, 7, 1, 75), 0, '0},
            '{mk(1, 700, 0, 0, 0), 0, '0},
            '{mk(1, 3000, 0, 0, 0), 0, '0},
            '{mk(1, 9000, 0, 0, 0), 0, '0},
            '{mk(1, 32'hFFFF_FFFF, 8'hFF, 1, -1), 0, '0}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[r]) send_item(directed[r].item, directed[r].typed, directed[r].val);

        clock_ms = $urandom;
        for (int ph = 0; ph < 7; ph++) begin
            drain_results();
            if (ph >= 5) begin
                taus[ph] = $urandom_range(0, 65535);
                depths[ph] = $urandom_range(0, 255);
                rates[ph] = $urandom_range(0, 65535);
            end
            reg_write(REG_DECAY, taus[ph]);
            reg_write(REG_DEPTH, depths[ph]);
            reg_write(REG_RATE, rates[ph]);
            idle_on = (ph != 1);
            if (ph == 2) hold_long = 1;
            tau_eff = (tau_cfg == 0) ? 1 : tau_cfg;
            items = 0;
            while (items < 105) begin
                if (ph == 3 && items >= 50 && items < 55) drain_results();
                if ($urandom_range(0, 9) < 8) begin
                    // touch, then a run of ticks with the clock moving forward
                    it = mk(0, clock_ms, $urandom_range(0, NPIN - 1), 1,
                            ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 160));
                    send_item(it);
                    items++;
                    burst = $urandom_range(2, 12);
                    repeat (burst) begin
                        if ($urandom_range(0, 9) == 0) clock_ms += $urandom;
                        else clock_ms += $urandom_range(0, 2 * tau_eff);
                        it = mk(1, clock_ms, $urandom, $urandom, $urandom);
                        send_item(it);
                        items++;
                    end
                end else begin
                    it = mk($urandom, $urandom, $urandom, $urandom, $urandom);
                    send_item(it);
                    items++;
                end
            end
        end

        drain_results();
        if (errors == 0 && pending_glow.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
